// ----- rtl/fba_pkg.sv -----
package fba_pkg;

   localparam int HEADER_COUNT    = 256;
   localparam int DATA_BLOCKS     = 48;
   localparam int BLOCK_BYTES     = 256;
   localparam int BLOCKS_PER_FILE = 5;

   localparam int SLOT_COUNT = 5;
   localparam int HDR_W      = (HEADER_COUNT > 1) ? $clog2(HEADER_COUNT) : 1;
   localparam int HCNT_W     = $clog2(HEADER_COUNT + 1);
   localparam int BLK_W      = (DATA_BLOCKS > 1) ? $clog2(DATA_BLOCKS) : 1;
   localparam int BCNT_W     = $clog2(DATA_BLOCKS + 1);

   // Header record: name, five packed block slots, block count.
   localparam int REC_W = 64 + 6 * SLOT_COUNT + 3;

   localparam logic [5:0] NO_BLOCK = 6'd63;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_TOO_BIG    = 3'd1;
   localparam logic [2:0] ST_FEW_BLOCKS = 3'd2;
   localparam logic [2:0] ST_NO_HEADER  = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd4;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load;        // capture request
      logic clr_scan;    // scan counters to zero
      logic step_blk;    // advance bitmap scan
      logic step_hdr;    // advance header scan
      logic take_blk;    // mark current block taken and record it
      logic free_slot;   // release the slot at the release counter
      logic step_slot;
      logic use_set;     // set in-use of the current header
      logic use_clr;     // clear it
      logic rec_wr;      // write header record
      logic set_result;  // latch result, status in status
      logic [2:0] status;
      logic from_rec;    // delete result takes slots from the record
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic       is_delete;
      logic       too_big;
      logic       blk_end;
      logic       blk_free;
      logic       enough_free;
      logic       got_all;
      logic       hdr_end;
      logic       hdr_used;
      logic       name_match;
      logic       slot_end;
   } stat_type;

   // Name with every byte from the first zero byte onward cleared.
   function automatic logic [63:0] canon_name(input logic [63:0] n);
      logic [63:0] r;
      logic        live;
      r    = '0;
      live = 1'b1;
      for (int b = 0; b < 8; b++) begin
         if (n[8*b +: 8] == 8'd0) live = 1'b0;
         if (live) r[8*b +: 8] = n[8*b +: 8];
      end
      return r;
   endfunction

endpackage

// ----- rtl/fba_ram.sv -----
module fba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/fba_datapath.sv -----
module fba_datapath (
   input  logic              clock,
   input  logic              reset,
   input  fba_pkg::cmd_type  cmd,
   output fba_pkg::stat_type stat,
   input  logic              req_func,
   input  logic [63:0]       req_name,
   input  logic [15:0]       req_bytes,
   output logic [2:0]        res_status,
   output logic [7:0]        res_index,
   output logic [2:0]        res_count,
   output logic [29:0]       res_slots
);
   import fba_pkg::*;

   logic                     func_ff;
   logic [63:0]              name_ff;
   logic [16:0]              need_ff;
   logic [HEADER_COUNT-1:0]  in_use_ff;
   logic [DATA_BLOCKS-1:0]   taken_ff;
   logic [BCNT_W-1:0]        free_ff, free_in;
   logic [BCNT_W-1:0]        blk_ff;
   logic [HCNT_W-1:0]        hdr_ff;
   logic [2:0]               got_ff;
   logic [29:0]              slots_ff;
   logic [2:0]               slot_ff;
   logic [2:0]               res_status_ff;
   logic [7:0]               res_index_ff;
   logic [2:0]               res_count_ff;
   logic [29:0]              res_slots_ff;
   logic [REC_W-1:0]         rd_rec;
   logic [HDR_W-1:0]         hdr_idx;
   logic [BLK_W-1:0]         blk_idx;
   logic [2:0]               rec_cnt;
   logic [5:0]               rel_blk;
   logic [16:0]              need_in;

   assign hdr_idx = hdr_ff[HDR_W-1:0];
   assign blk_idx = blk_ff[BLK_W-1:0];
   assign rec_cnt = (rd_rec[2:0] > 3'(SLOT_COUNT)) ? 3'(SLOT_COUNT) : rd_rec[2:0];
   assign rel_blk = rd_rec[3 + 6*slot_ff[2:0] +: 6];
   assign need_in = 17'((17'(req_bytes) + 17'(BLOCK_BYTES - 1)) / 17'(BLOCK_BYTES));

   // Header records; read address follows the header scan counter.
   fba_ram #(.WIDTH(REC_W), .DEPTH(HEADER_COUNT)) u_rec (
      .clock  (clock),
      .wr_en  (cmd.rec_wr),
      .wr_addr(hdr_idx),
      .wr_data({name_ff, slots_ff, got_ff}),
      .rd_addr(hdr_idx),
      .rd_data(rd_rec)
   );

   // Count of free blocks tracked alongside the bitmap.
   always_comb begin
      free_in = free_ff;
      if (cmd.take_blk) free_in = free_in - 1'b1;
      if (cmd.free_slot && slot_ff < rec_cnt && rel_blk < 6'(DATA_BLOCKS)
          && taken_ff[rel_blk[BLK_W-1:0]])
         free_in = free_in + 1'b1;
   end

   // Control state: flags, bitmap and free count.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
         taken_ff  <= '0;
         free_ff   <= BCNT_W'(DATA_BLOCKS);
      end else begin
         free_ff <= free_in;
         if (cmd.use_set) in_use_ff[hdr_idx] <= 1'b1;
         if (cmd.use_clr) in_use_ff[hdr_idx] <= 1'b0;
         if (cmd.take_blk) taken_ff[blk_idx] <= 1'b1;
         if (cmd.free_slot && slot_ff < rec_cnt && rel_blk < 6'(DATA_BLOCKS))
            taken_ff[rel_blk[BLK_W-1:0]] <= 1'b0;
      end
   end

   // Request capture, scan counters and result.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         name_ff <= canon_name(req_name);
         need_ff <= need_in;
      end
      if (cmd.clr_scan) begin
         blk_ff   <= '0;
         hdr_ff   <= '0;
         got_ff   <= '0;
         slot_ff  <= '0;
         slots_ff <= {SLOT_COUNT{NO_BLOCK}};
      end else begin
         if (cmd.step_blk) blk_ff <= blk_ff + 1'b1;
         if (cmd.step_hdr) hdr_ff <= hdr_ff + 1'b1;
         if (cmd.step_slot) slot_ff <= slot_ff + 1'b1;
         if (cmd.take_blk) begin
            slots_ff[6*got_ff +: 6] <= 6'(blk_ff);
            got_ff <= got_ff + 1'b1;
         end
      end
      if (cmd.set_result) begin
         res_status_ff <= cmd.status;
         if (cmd.status == ST_OK) begin
            res_index_ff <= 8'(hdr_ff);
            res_count_ff <= cmd.from_rec ? rec_cnt : got_ff;
            res_slots_ff <= cmd.from_rec ? rd_rec[32:3] : slots_ff;
         end else begin
            res_index_ff <= '0;
            res_count_ff <= '0;
            res_slots_ff <= {SLOT_COUNT{NO_BLOCK}};
         end
      end
   end

   assign stat.is_delete   = func_ff;
   assign stat.too_big     = need_ff > 17'(BLOCKS_PER_FILE);
   assign stat.enough_free = 17'(free_ff) >= need_ff;
   assign stat.blk_end     = blk_ff >= BCNT_W'(DATA_BLOCKS);
   assign stat.blk_free    = !taken_ff[blk_idx];
   assign stat.got_all     = 17'(got_ff) >= need_ff;
   assign stat.hdr_end     = hdr_ff >= HCNT_W'(HEADER_COUNT);
   assign stat.hdr_used    = in_use_ff[hdr_idx];
   assign stat.name_match  = rd_rec[REC_W-1 -: 64] == name_ff;
   assign stat.slot_end    = slot_ff >= rec_cnt;

   assign res_status = res_status_ff;
   assign res_index  = res_index_ff;
   assign res_count  = res_count_ff;
   assign res_slots  = res_slots_ff;

endmodule

// ----- rtl/fba_control.sv -----
module fba_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  fba_pkg::stat_type stat,
   output fba_pkg::cmd_type  cmd
);
   import fba_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_FIND_HDR, S_TAKE_BLK, S_COMMIT,
      S_DEL_SCAN, S_DEL_READ, S_DEL_CMP, S_RELEASE, S_DEL_DONE, S_FAIL
   } state_type;

   state_type  state_ff, state_in;
   logic       valid_ff, valid_in;
   logic [2:0] fail_ff, fail_in;
   logic       busy;

   assign busy       = state_ff != S_IDLE;
   assign req_tready = !busy && (!valid_ff || rsp_tready);
   assign rsp_tvalid = valid_ff;

   // Sequencer for create and delete.
   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && !rsp_tready;
      fail_in  = fail_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.load     = 1'b1;
               cmd.clr_scan = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.is_delete) state_in = S_DEL_SCAN;
            else if (stat.too_big) begin
               fail_in = ST_TOO_BIG; state_in = S_FAIL;
            end else if (!stat.enough_free) begin
               fail_in = ST_FEW_BLOCKS; state_in = S_FAIL;
            end else state_in = S_FIND_HDR;
         end
         S_FIND_HDR: begin
            if (stat.hdr_end) begin
               fail_in = ST_NO_HEADER; state_in = S_FAIL;
            end else if (!stat.hdr_used) state_in = S_TAKE_BLK;
            else cmd.step_hdr = 1'b1;
         end
         S_TAKE_BLK: begin
            if (stat.got_all || stat.blk_end) state_in = S_COMMIT;
            else begin
               cmd.take_blk = stat.blk_free;
               cmd.step_blk = 1'b1;
            end
         end
         S_COMMIT: begin
            cmd.use_set    = 1'b1;
            cmd.rec_wr     = 1'b1;
            cmd.set_result = 1'b1;
            cmd.status     = ST_OK;
            valid_in       = 1'b1;
            state_in       = S_IDLE;
         end
         S_DEL_SCAN: begin
            if (stat.hdr_end) begin
               fail_in = ST_NOT_FOUND; state_in = S_FAIL;
            end else if (stat.hdr_used) state_in = S_DEL_READ;
            else cmd.step_hdr = 1'b1;
         end
         S_DEL_READ: state_in = S_DEL_CMP;
         S_DEL_CMP: begin
            if (stat.name_match) state_in = S_RELEASE;
            else begin
               cmd.step_hdr = 1'b1;
               state_in     = S_DEL_SCAN;
            end
         end
         S_RELEASE: begin
            if (stat.slot_end) state_in = S_DEL_DONE;
            else begin
               cmd.free_slot = 1'b1;
               cmd.step_slot = 1'b1;
            end
         end
         S_DEL_DONE: begin
            cmd.use_clr    = 1'b1;
            cmd.set_result = 1'b1;
            cmd.status     = ST_OK;
            cmd.from_rec   = 1'b1;
            valid_in       = 1'b1;
            state_in       = S_IDLE;
         end
         S_FAIL: begin
            cmd.set_result = 1'b1;
            cmd.status     = fail_ff;
            valid_in       = 1'b1;
            state_in       = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         fail_ff  <= ST_OK;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         fail_ff  <= fail_in;
      end
   end

endmodule

// ----- rtl/file_block_allocator.sv -----
// File block allocator: a create request (func 0) takes the lowest free header and the
// lowest free data blocks, ceil(byte_count / 256) of them, up to five; a delete request
// (func 1) frees the lowest used header whose name matches and releases its blocks.
// One item is handled at a time. A create checks size and free block count, scans the
// headers one by one for the lowest free one, then scans the bitmap for free blocks;
// one rejected as too big or for too few blocks answers without a scan, and one with
// no free header answers after the whole header scan. A delete scans the headers one
// by one, reading and comparing the name of each used one, then releases the blocks
// of the match. The result waits in an output register, and the next item is taken
// once the result has been accepted.
module file_block_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // func
   input  logic [79:0] req_tdata,   // file_name [63:0], byte_count [79:64]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status [2:0], header_index [10:3], block_total [13:11], first_block [19:14],
   // second_block [25:20], third_block [31:26], fourth_block [37:32],
   // fifth_block [43:38], zero [47:44]
   output logic [47:0] rsp_tdata
);
   import fba_pkg::*;

   cmd_type     cmd;
   stat_type    stat;
   logic [2:0]  res_status;
   logic [7:0]  res_index;
   logic [2:0]  res_count;
   logic [29:0] res_slots;

   fba_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fba_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_func  (req_tuser),
      .req_name  (req_tdata[63:0]),
      .req_bytes (req_tdata[79:64]),
      .res_status(res_status),
      .res_index (res_index),
      .res_count (res_count),
      .res_slots (res_slots)
   );

   assign rsp_tdata = {4'd0, res_slots, res_count, res_index, res_status};

`ifndef SYNTHESIS
   // No item is taken while a result waits that the sink has not taken.
   a_no_accept_over_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request accepted over a pending result");

   // An accepted item cannot produce its result in the next cycle.
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid)
      else $error("result appeared too early");

   // A failed result carries no blocks.
   a_fail_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != ST_OK |-> rsp_tdata[13:11] == 3'd0)
      else $error("failed result carries blocks");
`endif

endmodule
